// ===== rtl/indexed_list_insert_erase_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list block
// Shared immediate-consequence and next-cycle property forms.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_ERASE_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ILIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ILIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ilie_pkg.sv =====
// ---------------------------------------------------------------------------
// ilie_pkg
// Types and constants shared by the indexed list cells, control and ports.
// ---------------------------------------------------------------------------
`default_nettype none

package ilie_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int ACT_W    = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_ERASE  = 3'd2,
        ACT_READ   = 3'd3,
        ACT_WRITE  = 3'd4
    } action_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_e;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INS,
        CELL_ERA
    } cell_kind_e;

    // broadcast to every cell each cycle
    typedef struct packed {
        cell_kind_e               kind;
        logic [CNT_W-1:0]         target;
        logic signed [WORD_W-1:0] word;
    } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/ilie_req_if.sv =====
// ---------------------------------------------------------------------------
// ilie_req_if
// Request channel: action, position and word, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ilie_req_if import ilie_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] word_in;

    modport source (output valid, action, position, word_in, input ready);
    modport sink (input valid, action, position, word_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilie_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ilie_rsp_if
// Response channel: status, word, count and empty flag, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface ilie_rsp_if import ilie_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] word_out;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;

    modport source (output valid, status, word_out, count, is_empty, input ready);
    modport sink (input valid, status, word_out, count, is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/ilie_cell.sv =====
// ---------------------------------------------------------------------------
// ilie_cell
// One list entry: holds, loads, or takes its left or right neighbor's word.
// ---------------------------------------------------------------------------
`default_nettype none

module ilie_cell import ilie_pkg::*; (
    input  wire logic                     clk,
    input  wire cell_op_t                 op,
    input  wire logic [IDX_W-1:0]         idx,
    input  wire logic signed [WORD_W-1:0] left,
    input  wire logic signed [WORD_W-1:0] right,
    output logic signed [WORD_W-1:0]      word
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic [CNT_W-1:0]         my_idx;

    assign my_idx = CNT_W'(idx);

    always_comb
    begin
        word_next = word_reg;
        case (op.kind)
            CELL_LOAD:
            begin
                if (my_idx == op.target)
                begin
                    word_next = op.word;
                end
            end
            CELL_INS:
            begin
                if (my_idx == op.target)
                begin
                    word_next = op.word;
                end
                else if (my_idx > op.target)
                begin
                    word_next = left;
                end
            end
            CELL_ERA:
            begin
                // entries past the tail pick up junk; they are never read
                if (my_idx >= op.target)
                begin
                    word_next = right;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// ===== rtl/ilie_ctrl.sv =====
// ---------------------------------------------------------------------------
// ilie_ctrl
// Request decode, element count, read select and registered response.
// ---------------------------------------------------------------------------
`default_nettype none

module ilie_ctrl import ilie_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    ilie_req_if.sink                      req,
    ilie_rsp_if.source                    rsp,
    input  wire logic signed [WORD_W-1:0] cell_word [CAPACITY],
    output cell_op_t                      op,
    output logic [CNT_W-1:0]              count
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic [STAT_W-1:0]        status_reg;
    logic signed [WORD_W-1:0] word_reg;
    logic [CNT_W-1:0]         rcount_reg;
    logic                     empty_reg;

    logic                     fire;
    logic                     in_range;
    logic                     full;
    status_e                  status_c;
    logic signed [WORD_W-1:0] word_c;
    cell_kind_e               kind_c;
    logic signed [WORD_W-1:0] rd_word;

    assign req.ready = !valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign in_range  = CNT_W'(req.position) < count_reg;
    assign full      = count_reg >= CAP;
    assign rd_word   = cell_word[req.position[IDX_W-1:0]];

    always_comb
    begin
        status_c   = ST_BAD;
        word_c     = '0;
        kind_c     = CELL_HOLD;
        count_next = count_reg;
        case (req.action)
            ACT_APPEND:
            begin
                if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    status_c   = ST_OK;
                    kind_c     = CELL_LOAD;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_INSERT:
            begin
                if (CNT_W'(req.position) > count_reg)
                begin
                    status_c = ST_BAD;
                end
                else if (full)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    status_c   = ST_OK;
                    kind_c     = CELL_INS;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_ERASE:
            begin
                if (in_range)
                begin
                    status_c   = ST_OK;
                    word_c     = rd_word;
                    kind_c     = CELL_ERA;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_READ:
            begin
                if (in_range)
                begin
                    status_c = ST_OK;
                    word_c   = rd_word;
                end
            end
            ACT_WRITE:
            begin
                if (in_range)
                begin
                    status_c = ST_OK;
                    kind_c   = CELL_LOAD;
                end
            end
            default:
            begin
                status_c = ST_BAD;
            end
        endcase
    end

    // append targets the tail slot, everything else the requested slot
    always_comb
    begin
        op.kind   = fire ? kind_c : CELL_HOLD;
        op.target = (req.action == ACT_APPEND) ? count_reg : CNT_W'(req.position);
        op.word   = req.word_in;
    end

    assign valid_next = fire || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_c;
            word_reg   <= word_c;
            rcount_reg <= count_next;
            empty_reg  <= (count_next == '0);
        end
    end

    assign rsp.valid    = valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.word_out = word_reg;
    assign rsp.count    = rcount_reg;
    assign rsp.is_empty = empty_reg;
    assign count        = count_reg;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_erase.sv =====
// The response is registered: it is valid in the cycle after the request beat.
// Throughput: one request per cycle; the response register frees on the
// same edge it is taken, so requests stall only while a response waits.
// Insert and erase shift every cell past the target at once, on the accepting edge.
// Reset: count and response valid clear asynchronously; entry contents are
// left as they are and only read after being written.
// ---------------------------------------------------------------------------
// indexed_list_insert_erase
// Fixed-capacity ordered list of signed words built from a row of cells.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_erase_assert.svh"

module indexed_list_insert_erase import ilie_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ilie_req_if.sink   req,
    ilie_rsp_if.source rsp
);

    cell_op_t                 op;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] cell_word [CAPACITY];

    ilie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cell_word (cell_word),
        .op        (op),
        .count     (count)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left;
        logic signed [WORD_W-1:0] right;

        if (i == 0)
        begin : g_head
            assign left = op.word;
        end
        else
        begin : g_mid_l
            assign left = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right = cell_word[i];
        end
        else
        begin : g_mid_r
            assign right = cell_word[i+1];
        end

        ilie_cell u_cell (
            .clk   (clk),
            .op    (op),
            .idx   (IDX_W'(i)),
            .left  (left),
            .right (right),
            .word  (cell_word[i])
        );
    end

    `ILIE_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY),
        "element count exceeds capacity")
    `ILIE_ASSERT_NEXT(a_fire_rsp, req.valid && req.ready, rsp.valid,
        "accepted request produced no response")
    `ILIE_ASSERT_NEXT(a_erase_dec,
        req.valid && req.ready && req.action == ACT_ERASE
            && CNT_W'(req.position) < count,
        count == $past(count) - 1'b1,
        "erase did not shrink the list by one")

endmodule

`default_nettype wire
